// ===== rtl/mlfq_pkg.sv =====
// ----------------------------------------------------------------------------
// mlfq_pkg
// Shared types and constants of the multilevel feedback queue tick scheduler.
// ----------------------------------------------------------------------------
package mlfq_pkg;

  // fixed field widths
  localparam int ID_W      = 4;
  localparam int TIME_W    = 16;
  localparam int NLV_W     = 3;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_W     = 16;
  localparam int OUT_LVL_W = 2;
  // level index carried between modules, covers up to eight levels
  localparam int LVL_IDX_W = 3;

  // request function codes
  localparam logic FUNC_TICK = 1'b1;

  // register reset values
  localparam logic [NLV_W-1:0]  NUM_LEVELS_RST = 3'd4;
  localparam logic [TIME_W-1:0] QUANTUM0_RST   = 16'd2;
  localparam logic [TIME_W-1:0] QUANTUM1_RST   = 16'd4;
  localparam logic [TIME_W-1:0] QUANTUM2_RST   = 16'd8;
  localparam logic [TIME_W-1:0] USED_MAX       = 16'hFFFF;

  // configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_NUM_LEVELS = 2'd0,
    CFG_QUANTUM0   = 2'd1,
    CFG_QUANTUM1   = 2'd2,
    CFG_QUANTUM2   = 2'd3
  } cfg_reg_t;

  // sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ARRIVE,
    ST_DEM_CHK,
    ST_DEM_WR,
    ST_RUN_SEL,
    ST_RUN_ID,
    ST_RUN_REM,
    ST_DONE
  } state_t;

  // update commands for the per-level queue registers
  typedef struct packed {
    logic                 push;
    logic [LVL_IDX_W-1:0] push_lvl;
    logic                 pop;
    logic [LVL_IDX_W-1:0] pop_lvl;
    logic                 used_upd;
    logic                 used_clr;
    logic [LVL_IDX_W-1:0] used_lvl;
  } lvl_cmd_t;

endpackage

// ===== rtl/mlfq_tick_scheduler_top.sv =====
// ----------------------------------------------------------------------------
// mlfq_tick_scheduler_top
// Multilevel feedback queue scheduler: arrivals join level 0, ticks demote
// expired level heads and run the head of the highest non-empty level.
// ----------------------------------------------------------------------------
// Arrival: IDLE accepts, ARRIVE writes, DONE loads the result, result registered.
// Tick: DEM_CHK per active level and DEM_WR per demotion, then RUN_SEL, RUN_ID,
//   RUN_REM (only RUN_SEL when nothing runs) and DONE; each demotion is a read
//   and a write of the level queue RAM, and running reads the queue RAM then the remaining-time RAM.
// Reset clears the control state and level counters; the RAMs need no clearing,
//   no entry's value is used before it is written. Requests are taken only in IDLE.
module mlfq_tick_scheduler_top #(
  parameter int MAX_PROCS      = 16,
  parameter int NUM_LEVELS_MAX = 4
) (
  input  logic                             clk,
  input  logic                             rst,
  // request channel
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic                             func,
  input  logic [mlfq_pkg::ID_W-1:0]        proc_id,
  input  logic [mlfq_pkg::TIME_W-1:0]      burst_len,
  // result channel
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic                             ran_valid,
  output logic [mlfq_pkg::ID_W-1:0]        ran_id,
  output logic [mlfq_pkg::OUT_LVL_W-1:0]   ran_level,
  output logic                             finished,
  output logic                             rejected,
  // configuration write channel
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [mlfq_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [mlfq_pkg::CFG_W-1:0]       cfg_data
);

  localparam int HEAD_W = $clog2(MAX_PROCS);
  localparam int LVC_W  = $clog2(NUM_LEVELS_MAX + 1);
  localparam int LVL_W  = (NUM_LEVELS_MAX > 1) ? $clog2(NUM_LEVELS_MAX) : 1;
  localparam int FDEPTH = NUM_LEVELS_MAX * MAX_PROCS;
  localparam int FA_W   = $clog2(FDEPTH);
  localparam int PA_W   = $clog2(MAX_PROCS);
  localparam int ID_W   = mlfq_pkg::ID_W;
  localparam int TIME_W = mlfq_pkg::TIME_W;

  // configuration registers
  logic [mlfq_pkg::NLV_W-1:0] nlv_q;
  logic [TIME_W-1:0]          q0_q;
  logic [TIME_W-1:0]          q1_q;
  logic [TIME_W-1:0]          q2_q;
  logic [LVC_W-1:0]           n_eff;

  // sequencer
  mlfq_pkg::state_t state;
  mlfq_pkg::state_t state_next;
  logic [ID_W-1:0]   id_q;
  logic [TIME_W-1:0] burst_q;
  logic [LVL_W-1:0]  lv_q;
  logic [LVL_W-1:0]  sel_q;
  logic [ID_W-1:0]   pid_q;
  logic [LVL_W:0]    lv_p1;
  logic [LVL_W-1:0]  lv_nx;
  logic              dem_last;
  logic              run_any;
  logic [LVL_W-1:0]  run_lvl;

  // pending result
  logic                            res_ran_valid;
  logic [ID_W-1:0]                 res_ran_id;
  logic [mlfq_pkg::OUT_LVL_W-1:0]  res_ran_level;
  logic                            res_finished;
  logic                            res_rejected;
  logic                            load_out;

  // level queue state
  logic [NUM_LEVELS_MAX-1:0][HEAD_W-1:0] head;
  logic [NUM_LEVELS_MAX-1:0][HEAD_W-1:0] tail;
  logic [NUM_LEVELS_MAX-1:0]             nonempty;
  logic [NUM_LEVELS_MAX-1:0]             full;
  logic [NUM_LEVELS_MAX-1:0]             can_demote;
  mlfq_pkg::lvl_cmd_t                    cmd;
  logic [MAX_PROCS-1:0]                  active;

  // memory ports
  logic              fifo_we;
  logic [FA_W-1:0]   fifo_waddr;
  logic [ID_W-1:0]   fifo_wdata;
  logic [FA_W-1:0]   fifo_raddr;
  logic [ID_W-1:0]   fifo_rdata;
  logic              rem_we;
  logic [PA_W-1:0]   rem_waddr;
  logic [TIME_W-1:0] rem_wdata;
  logic [PA_W-1:0]   rem_raddr;
  logic [TIME_W-1:0] rem_rdata;

  // decisions
  logic              arr_rej;
  logic [TIME_W-1:0] rem_new;
  logic              run_fin;

  function automatic logic [FA_W-1:0] fifo_addr(input logic [LVL_W-1:0] lvl,
                                                input logic [HEAD_W-1:0] slot);
    fifo_addr = FA_W'(lvl) * FA_W'(MAX_PROCS) + FA_W'(slot);
  endfunction

  mlfq_ram #(
    .WIDTH (ID_W),
    .DEPTH (FDEPTH)
  ) u_fifo_ram (
    .clk   (clk),
    .we    (fifo_we),
    .waddr (fifo_waddr),
    .wdata (fifo_wdata),
    .raddr (fifo_raddr),
    .rdata (fifo_rdata)
  );

  mlfq_ram #(
    .WIDTH (TIME_W),
    .DEPTH (MAX_PROCS)
  ) u_rem_ram (
    .clk   (clk),
    .we    (rem_we),
    .waddr (rem_waddr),
    .wdata (rem_wdata),
    .raddr (rem_raddr),
    .rdata (rem_rdata)
  );

  mlfq_lvl #(
    .MAX_PROCS      (MAX_PROCS),
    .NUM_LEVELS_MAX (NUM_LEVELS_MAX)
  ) u_lvl (
    .clk        (clk),
    .rst        (rst),
    .n_eff      (n_eff),
    .quantum0   (q0_q),
    .quantum1   (q1_q),
    .quantum2   (q2_q),
    .cmd        (cmd),
    .head       (head),
    .tail       (tail),
    .nonempty   (nonempty),
    .full       (full),
    .can_demote (can_demote)
  );

  // effective level count, clamped to one..max
  always_comb begin
    if (nlv_q == '0) begin
      n_eff = LVC_W'(1);
    end else if (int'(nlv_q) > NUM_LEVELS_MAX) begin
      n_eff = LVC_W'(NUM_LEVELS_MAX);
    end else begin
      n_eff = LVC_W'(nlv_q);
    end
  end

  // demotion sweep position
  assign lv_p1    = (LVL_W + 1)'(lv_q) + (LVL_W + 1)'(1);
  assign lv_nx    = lv_p1[LVL_W-1:0];
  assign dem_last = (lv_p1 >= (LVL_W + 1)'(n_eff));

  // highest non-empty level
  always_comb begin
    run_any = 1'b0;
    run_lvl = '0;
    for (int l = NUM_LEVELS_MAX - 1; l >= 0; l--) begin
      if (nonempty[l]) begin
        run_any = 1'b1;
        run_lvl = LVL_W'(l);
      end
    end
  end

  // arrival and run decisions
  assign arr_rej = (int'(id_q) >= MAX_PROCS) || active[PA_W'(id_q)] || full[0];
  assign rem_new = (rem_rdata != '0) ? rem_rdata - TIME_W'(1) : '0;
  assign run_fin = (rem_new == '0);

  // next state
  always_comb begin
    state_next = state;
    case (state)
      mlfq_pkg::ST_IDLE: begin
        if (in_valid) begin
          state_next = (func == mlfq_pkg::FUNC_TICK) ? mlfq_pkg::ST_DEM_CHK
                                                     : mlfq_pkg::ST_ARRIVE;
        end
      end
      mlfq_pkg::ST_ARRIVE:  state_next = mlfq_pkg::ST_DONE;
      mlfq_pkg::ST_DEM_CHK: begin
        if (dem_last) begin
          state_next = mlfq_pkg::ST_RUN_SEL;
        end else if (can_demote[lv_q]) begin
          state_next = mlfq_pkg::ST_DEM_WR;
        end
      end
      mlfq_pkg::ST_DEM_WR:  state_next = mlfq_pkg::ST_DEM_CHK;
      mlfq_pkg::ST_RUN_SEL: begin
        state_next = run_any ? mlfq_pkg::ST_RUN_ID : mlfq_pkg::ST_DONE;
      end
      mlfq_pkg::ST_RUN_ID:  state_next = mlfq_pkg::ST_RUN_REM;
      mlfq_pkg::ST_RUN_REM: state_next = mlfq_pkg::ST_DONE;
      mlfq_pkg::ST_DONE: begin
        if (load_out) begin
          state_next = mlfq_pkg::ST_IDLE;
        end
      end
      default: state_next = mlfq_pkg::ST_IDLE;
    endcase
  end

  // state outputs: memory ports, queue commands, handshake
  always_comb begin
    in_stall   = 1'b1;
    load_out   = 1'b0;
    fifo_we    = 1'b0;
    fifo_waddr = '0;
    fifo_wdata = '0;
    fifo_raddr = '0;
    rem_we     = 1'b0;
    rem_waddr  = '0;
    rem_wdata  = '0;
    rem_raddr  = '0;
    cmd        = '0;
    case (state)
      mlfq_pkg::ST_IDLE: begin
        in_stall = 1'b0;
      end
      mlfq_pkg::ST_ARRIVE: begin
        if (!arr_rej) begin
          fifo_we      = 1'b1;
          fifo_waddr   = fifo_addr('0, tail[0]);
          fifo_wdata   = id_q;
          rem_we       = 1'b1;
          rem_waddr    = PA_W'(id_q);
          rem_wdata    = (burst_q == '0) ? TIME_W'(1) : burst_q;
          cmd.push     = 1'b1;
          cmd.push_lvl = '0;
        end
      end
      mlfq_pkg::ST_DEM_CHK: begin
        fifo_raddr = fifo_addr(lv_q, head[lv_q]);
      end
      mlfq_pkg::ST_DEM_WR: begin
        fifo_we      = 1'b1;
        fifo_waddr   = fifo_addr(lv_nx, tail[lv_nx]);
        fifo_wdata   = fifo_rdata;
        cmd.push     = 1'b1;
        cmd.push_lvl = mlfq_pkg::LVL_IDX_W'(lv_nx);
        cmd.pop      = 1'b1;
        cmd.pop_lvl  = mlfq_pkg::LVL_IDX_W'(lv_q);
        cmd.used_upd = 1'b1;
        cmd.used_clr = 1'b1;
        cmd.used_lvl = mlfq_pkg::LVL_IDX_W'(lv_q);
      end
      mlfq_pkg::ST_RUN_SEL: begin
        fifo_raddr = fifo_addr(run_lvl, head[run_lvl]);
      end
      mlfq_pkg::ST_RUN_ID: begin
        rem_raddr = PA_W'(fifo_rdata);
      end
      mlfq_pkg::ST_RUN_REM: begin
        rem_we       = 1'b1;
        rem_waddr    = PA_W'(pid_q);
        rem_wdata    = rem_new;
        cmd.pop      = run_fin;
        cmd.pop_lvl  = mlfq_pkg::LVL_IDX_W'(sel_q);
        cmd.used_upd = 1'b1;
        cmd.used_clr = run_fin;
        cmd.used_lvl = mlfq_pkg::LVL_IDX_W'(sel_q);
      end
      mlfq_pkg::ST_DONE: begin
        load_out = !out_valid || !out_stall;
      end
      default: begin
        in_stall = 1'b1;
      end
    endcase
  end

  // configuration port, always ready; the user must make writes between requests, the block does not enforce it
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      nlv_q <= mlfq_pkg::NUM_LEVELS_RST;
      q0_q  <= mlfq_pkg::QUANTUM0_RST;
      q1_q  <= mlfq_pkg::QUANTUM1_RST;
      q2_q  <= mlfq_pkg::QUANTUM2_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (mlfq_pkg::cfg_reg_t'(cfg_index))
        mlfq_pkg::CFG_NUM_LEVELS: nlv_q <= cfg_data[mlfq_pkg::NLV_W-1:0];
        mlfq_pkg::CFG_QUANTUM0:   q0_q  <= cfg_data;
        mlfq_pkg::CFG_QUANTUM1:   q1_q  <= cfg_data;
        mlfq_pkg::CFG_QUANTUM2:   q2_q  <= cfg_data;
        default:                  nlv_q <= nlv_q;
      endcase
    end
  end

  // control state, active flags and result valid
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= mlfq_pkg::ST_IDLE;
      active    <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (state == mlfq_pkg::ST_ARRIVE && !arr_rej) begin
        active[PA_W'(id_q)] <= 1'b1;
      end
      if (state == mlfq_pkg::ST_RUN_REM && run_fin) begin
        active[PA_W'(pid_q)] <= 1'b0;
      end
      if (load_out) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  // request capture, sweep indexes and result payload
  always_ff @(posedge clk) begin
    if (state == mlfq_pkg::ST_IDLE && in_valid) begin
      id_q          <= proc_id;
      burst_q       <= burst_len;
      lv_q          <= '0;
      res_ran_valid <= 1'b0;
      res_ran_id    <= '0;
      res_ran_level <= '0;
      res_finished  <= 1'b0;
      res_rejected  <= 1'b0;
    end
    if (state == mlfq_pkg::ST_ARRIVE) begin
      res_rejected <= arr_rej;
    end
    if ((state == mlfq_pkg::ST_DEM_CHK && !dem_last && !can_demote[lv_q])
        || state == mlfq_pkg::ST_DEM_WR) begin
      lv_q <= lv_nx;
    end
    if (state == mlfq_pkg::ST_RUN_SEL) begin
      sel_q <= run_lvl;
    end
    if (state == mlfq_pkg::ST_RUN_ID) begin
      pid_q <= fifo_rdata;
    end
    if (state == mlfq_pkg::ST_RUN_REM) begin
      res_ran_valid <= 1'b1;
      res_ran_id    <= pid_q;
      res_ran_level <= mlfq_pkg::OUT_LVL_W'(sel_q);
      res_finished  <= run_fin;
    end
    if (load_out) begin
      ran_valid <= res_ran_valid;
      ran_id    <= res_ran_id;
      ran_level <= res_ran_level;
      finished  <= res_finished;
      rejected  <= res_rejected;
    end
  end

  // an accepted request always starts arrival or tick work
  a_accept_starts: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |=>
      (state == mlfq_pkg::ST_ARRIVE || state == mlfq_pkg::ST_DEM_CHK))
    else $error("accepted request did not start processing");

  // a demotion only writes into a level with room
  a_demote_room: assert property (@(posedge clk) disable iff (rst)
    (state == mlfq_pkg::ST_DEM_WR) |-> !full[lv_nx])
    else $error("demotion into a full level");

  // the process taken to run is active
  a_run_active: assert property (@(posedge clk) disable iff (rst)
    (state == mlfq_pkg::ST_RUN_REM) |-> active[PA_W'(pid_q)])
    else $error("running process is not active");

  // a result is either an arrival outcome or a tick outcome
  a_result_kind: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (!(rejected && ran_valid) && !(finished && !ran_valid)))
    else $error("inconsistent result flags");

endmodule

// ===== rtl/mlfq_ram.sv =====
// ----------------------------------------------------------------------------
// mlfq_ram
// Generic single write port RAM with one registered read port.
// ----------------------------------------------------------------------------
module mlfq_ram #(
  parameter int WIDTH = 4,
  parameter int DEPTH = 64,
  localparam int AW   = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

// ===== rtl/mlfq_lvl.sv =====
// ----------------------------------------------------------------------------
// mlfq_lvl
// Per-level queue registers: ring head, fill count and used-time counter,
// with the tail position, status flags and demotion condition of each level.
// ----------------------------------------------------------------------------
module mlfq_lvl #(
  parameter int MAX_PROCS      = 16,
  parameter int NUM_LEVELS_MAX = 4,
  localparam int HEAD_W        = $clog2(MAX_PROCS),
  localparam int CNT_W         = $clog2(MAX_PROCS + 1),
  localparam int LVC_W         = $clog2(NUM_LEVELS_MAX + 1)
) (
  input  logic                                    clk,
  input  logic                                    rst,
  input  logic [LVC_W-1:0]                        n_eff,
  input  logic [mlfq_pkg::TIME_W-1:0]             quantum0,
  input  logic [mlfq_pkg::TIME_W-1:0]             quantum1,
  input  logic [mlfq_pkg::TIME_W-1:0]             quantum2,
  input  mlfq_pkg::lvl_cmd_t                      cmd,
  output logic [NUM_LEVELS_MAX-1:0][HEAD_W-1:0]   head,
  output logic [NUM_LEVELS_MAX-1:0][HEAD_W-1:0]   tail,
  output logic [NUM_LEVELS_MAX-1:0]               nonempty,
  output logic [NUM_LEVELS_MAX-1:0]               full,
  output logic [NUM_LEVELS_MAX-1:0]               can_demote
);

  for (genvar l = 0; l < NUM_LEVELS_MAX; l++) begin : g_lane
    logic [HEAD_W-1:0]           head_q;
    logic [CNT_W-1:0]            cnt_q;
    logic [mlfq_pkg::TIME_W-1:0] used_q;
    logic [mlfq_pkg::TIME_W-1:0] quant;
    logic [CNT_W:0]              tail_sum;
    logic [HEAD_W:0]             head_inc;
    logic                        hit_push;
    logic                        hit_pop;
    logic                        hit_used;

    // quantum of this level, levels past the third have none
    if (l == 0) begin : g_q0
      assign quant = quantum0;
    end else if (l == 1) begin : g_q1
      assign quant = quantum1;
    end else if (l == 2) begin : g_q2
      assign quant = quantum2;
    end else begin : g_qn
      assign quant = '0;
    end

    // command decode for this lane
    assign hit_push = cmd.push && (cmd.push_lvl == mlfq_pkg::LVL_IDX_W'(l));
    assign hit_pop  = cmd.pop && (cmd.pop_lvl == mlfq_pkg::LVL_IDX_W'(l));
    assign hit_used = cmd.used_upd && (cmd.used_lvl == mlfq_pkg::LVL_IDX_W'(l));

    // ring positions, sum stays below twice the ring size
    assign tail_sum = (CNT_W + 1)'(head_q) + (CNT_W + 1)'(cnt_q);
    assign head_inc = (HEAD_W + 1)'(head_q) + (HEAD_W + 1)'(1);
    assign tail[l]  = (tail_sum >= (CNT_W + 1)'(MAX_PROCS))
                    ? HEAD_W'(tail_sum - (CNT_W + 1)'(MAX_PROCS))
                    : HEAD_W'(tail_sum);
    assign head[l]     = head_q;
    assign nonempty[l] = (cnt_q != '0);
    assign full[l]     = (cnt_q == CNT_W'(MAX_PROCS));

    // demotion condition, lowest level never demotes
    if (l + 1 < NUM_LEVELS_MAX) begin : g_dem
      assign can_demote[l] = nonempty[l] && (used_q >= quant) && !full[l + 1]
                          && (LVC_W'(l + 1) < n_eff);
    end else begin : g_last
      assign can_demote[l] = 1'b0;
    end

    // queue state update
    always_ff @(posedge clk) begin
      if (rst) begin
        head_q <= '0;
        cnt_q  <= '0;
        used_q <= '0;
      end else begin
        if (hit_pop) begin
          head_q <= (head_inc == (HEAD_W + 1)'(MAX_PROCS)) ? '0 : HEAD_W'(head_inc);
        end
        cnt_q <= cnt_q + CNT_W'(hit_push) - CNT_W'(hit_pop);
        if (hit_used) begin
          if (cmd.used_clr) begin
            used_q <= '0;
          end else if (used_q != mlfq_pkg::USED_MAX) begin
            used_q <= used_q + mlfq_pkg::TIME_W'(1);
          end
        end
      end
    end
  end

endmodule
